@@ rtl/dfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the delimited field selector: register
// indexes, fixed field widths and the job handed to the output sequencer.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int ByteW    = 8;
  localparam int RegW     = 64;
  localparam int CntW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int SelIdxW  = 6;

  localparam logic [ByteW-1:0] NEWLINE = 8'd10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IN_DELIM_BYTES  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IN_DELIM_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_OUT_DELIM_BYTES = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OUT_DELIM_LEN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIELD_SELECT    = 3'd4;

  // one input byte's worth of output: separator bytes, then optionally the byte
  typedef struct packed {
    logic [CntW-1:0]  sep_len;
    logic [ByteW-1:0] data_byte;
    logic             byte_en;
  } dfs_job_t;

endpackage : dfs_pkg
`default_nettype wire

@@ rtl/dfs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_if
// Channel interfaces of the delimited field selector: text input, selected
// text output and configuration write.
// ----------------------------------------------------------------------------
interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface : dfs_in_if

interface dfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface : dfs_out_if

interface dfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : dfs_cfg_if
`default_nettype wire

@@ rtl/dfs_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_emit
// Output sequencer: plays out one job a byte per cycle while not stalled,
// separator bytes first, then the token byte; flags each job's last byte.
// ----------------------------------------------------------------------------
module dfs_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  input  wire dfs_pkg::dfs_job_t job,
  input  wire logic [63:0]      sep_bytes,
  output logic                  take,
  dfs_out_if.source             out_chan
);
  import dfs_pkg::*;

  logic             valid_r, valid_nxt;
  logic [CntW-1:0]  sep_left_r, sep_left_nxt;
  logic [2:0]       pos_r, pos_nxt;
  dfs_job_t         job_r, job_nxt;
  logic             last_beat;
  logic             fire;

  assign last_beat = (sep_left_r == '0) ||
                     ((sep_left_r == CntW'(1)) && !job_r.byte_en);
  assign fire      = valid_r && out_chan.ready;
  assign take      = !valid_r || (out_chan.ready && last_beat);

  always_comb begin
    out_chan.valid    = valid_r;
    out_chan.run_last = last_beat;
    if (sep_left_r != '0) begin
      out_chan.out_byte = sep_bytes[{pos_r, 3'b000} +: ByteW];
    end else begin
      out_chan.out_byte = job_r.data_byte;
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    sep_left_nxt = sep_left_r;
    pos_nxt      = pos_r;
    job_nxt      = job_r;
    if (take) begin
      valid_nxt    = job_valid;
      sep_left_nxt = job.sep_len;
      pos_nxt      = '0;
      job_nxt      = job;
    end else if (fire) begin
      // still inside the separator run
      sep_left_nxt = sep_left_r - CntW'(1);
      pos_nxt      = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sep_left_r <= '0;
      pos_r      <= '0;
    end else begin
      valid_r    <= valid_nxt;
      sep_left_r <= sep_left_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule : dfs_emit
`default_nettype wire

@@ rtl/delimited_field_selector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_field_selector
// Splits a byte stream into delimiter-separated tokens per line and passes
// the selected tokens on, joined by a separator string; newline passes through.
// ----------------------------------------------------------------------------
//   channel   dir  payload              transaction
//   in_chan   in   in_byte              one text byte
//   out_chan  out  out_byte, run_last   one output byte
//   cfg_chan  in   index, data          one register write, always ready
//
// Each byte is classified in the cycle it is taken and queued as a job in a
// one-entry holding register ahead of the output sequencer, so a byte per
// cycle flows when each causes at most one output byte and out_chan is not
// stalled. A byte that starts a selected token after an earlier one is put out
// behind out_delim_len separator bytes (length clamped to DELIM_MAX). Reset
// (rst_n low, synchronous) empties both job registers and clears the line
// state; output stalls back up through the holding register to in_chan.ready.
// ----------------------------------------------------------------------------
module delimited_field_selector #(
  parameter int MAX_FIELDS = 64,
  parameter int DELIM_MAX  = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dfs_in_if.sink     in_chan,
  dfs_out_if.source  out_chan,
  dfs_cfg_if.sink    cfg_chan
);
  import dfs_pkg::*;

  localparam int TokW = $clog2(MAX_FIELDS + 2);

  // configuration
  logic [RegW-1:0] in_delim_bytes_r;
  logic [CntW-1:0] in_delim_count_r;
  logic [RegW-1:0] out_delim_bytes_r;
  logic [CntW-1:0] out_delim_len_r;
  logic [RegW-1:0] field_select_r;

  // line state
  logic [TokW-1:0] tok_r, tok_nxt;
  logic            inside_r, inside_nxt;
  logic            emitted_r, emitted_nxt;

  // holding register
  logic            hold_valid_r, hold_valid_nxt;
  dfs_job_t        hold_job_r, hold_job_nxt;

  logic            take;
  logic            in_fire;
  logic            is_nl;
  logic            is_delim;
  logic [CntW-1:0] in_cnt_c;
  logic [CntW-1:0] out_len_c;
  logic            tok_sel;
  logic [6:0]      tok_m1;
  dfs_job_t        new_job;
  logic            new_valid;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !hold_valid_r || take;
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign in_cnt_c  = (in_delim_count_r > CntW'(DELIM_MAX)) ? CntW'(DELIM_MAX)
                                                           : in_delim_count_r;
  assign out_len_c = (out_delim_len_r > CntW'(DELIM_MAX)) ? CntW'(DELIM_MAX)
                                                          : out_delim_len_r;
  assign is_nl     = (in_chan.in_byte == NEWLINE);

  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < DELIM_MAX; i++) begin
      if ((CntW'(i) < in_cnt_c) && (in_delim_bytes_r[8*i +: 8] == in_chan.in_byte)) begin
        is_delim = 1'b1;
      end
    end
  end

  // classification and line state update
  always_comb begin
    tok_nxt             = tok_r;
    inside_nxt          = inside_r;
    emitted_nxt         = emitted_r;
    new_job.sep_len     = '0;
    new_job.data_byte   = in_chan.in_byte;
    new_job.byte_en     = 1'b0;
    tok_sel             = 1'b0;
    tok_m1              = '0;
    if (is_nl) begin
      tok_nxt         = '0;
      inside_nxt      = 1'b0;
      emitted_nxt     = 1'b0;
      new_job.byte_en = 1'b1;
    end else if (is_delim) begin
      inside_nxt = 1'b0;
    end else begin
      inside_nxt = 1'b1;
      if (!inside_r && (tok_r < TokW'(MAX_FIELDS + 1))) begin
        tok_nxt = tok_r + TokW'(1);
      end
      tok_m1  = 7'(tok_nxt) - 7'd1;
      tok_sel = (tok_nxt != '0) && (tok_nxt <= TokW'(MAX_FIELDS)) &&
                field_select_r[tok_m1[SelIdxW-1:0]];
      if (!inside_r && tok_sel) begin
        // separator only ahead of a token that is not the first selected one
        if (emitted_r) begin
          new_job.sep_len = out_len_c;
        end
        emitted_nxt = 1'b1;
      end
      new_job.byte_en = tok_sel;
    end
  end

  assign new_valid = new_job.byte_en || (new_job.sep_len != '0);

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_job_nxt   = hold_job_r;
    if (in_fire) begin
      hold_valid_nxt = new_valid;
      hold_job_nxt   = new_job;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r        <= '0;
      inside_r     <= 1'b0;
      emitted_r    <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (in_fire) begin
        tok_r     <= tok_nxt;
        inside_r  <= inside_nxt;
        emitted_r <= emitted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_job_r <= hold_job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_delim_bytes_r  <= '0;
      in_delim_count_r  <= CntW'(1);
      out_delim_bytes_r <= '0;
      out_delim_len_r   <= CntW'(1);
      field_select_r    <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_IN_DELIM_BYTES:  in_delim_bytes_r  <= cfg_chan.data;
        CFG_IN_DELIM_COUNT:  in_delim_count_r  <= cfg_chan.data[CntW-1:0];
        CFG_OUT_DELIM_BYTES: out_delim_bytes_r <= cfg_chan.data;
        CFG_OUT_DELIM_LEN:   out_delim_len_r   <= cfg_chan.data[CntW-1:0];
        CFG_FIELD_SELECT:    field_select_r    <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  dfs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (hold_valid_r),
    .job       (hold_job_r),
    .sep_bytes (out_delim_bytes_r),
    .take      (take),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_sep_has_byte : assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && (hold_job_r.sep_len != '0)) |-> hold_job_r.byte_en)
    else $error("separator job without token byte");

  a_tok_sat : assert property (@(posedge clk) disable iff (!rst_n)
    tok_r <= TokW'(MAX_FIELDS + 1))
    else $error("token count beyond saturation");

  a_nl_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_nl) |=> ((tok_r == '0) && !inside_r && !emitted_r))
    else $error("newline left line state set");

  a_free_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !hold_valid_r |-> in_chan.ready)
    else $error("input stalled with empty holding register");
`endif

endmodule : delimited_field_selector
`default_nettype wire
